>>> rtl/core/bnfpa_pkg.sv
`default_nettype none

package bnfpa_pkg;

    localparam int unsigned BITMAP_BYTES_DEF = 4096;
    localparam int unsigned START_PAGE_DEF   = 1;

    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned PNUM_W  = 15;
    localparam int unsigned LIMIT_W = 16;
    // Internal page numbers cover the end of the longest run.
    localparam int unsigned PAGE_W  = 17;
    localparam int unsigned BYTE_W  = PAGE_W - 3;

    localparam logic [TYPE_W-1:0] REQ_ALLOC    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE     = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_MARK     = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_RUN_FREE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_RUN_MARK = 3'd4;

    typedef enum logic [1:0] {
        WALK_FIND,
        WALK_SET,
        WALK_CLR
    } t_walk_mode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_WRAP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic init_step;
        logic load;
        logic setup;
        logic wrap;
        logic walk;
        logic res_ok;
        logic res_fail;
        logic ptr_reset;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic is_alloc;
        logic is_walk;
        logic empty;
        logic hit;
        logic last;
        logic ptr_start;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/core/bnfpa_ram.sv
`default_nettype none

module bnfpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/bnfpa_ctrl.sv
`default_nettype none

module bnfpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bnfpa_pkg::t_dp_sts i_sts,
    output bnfpa_pkg::t_dp_cmd o_cmd
);

    import bnfpa_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   r_wrap, n_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_out_vld <= 1'b0;
            r_wrap    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_wrap    <= n_wrap;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld & ~i_out_ready;
        n_wrap     = r_wrap;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_wrap      = 1'b0;
                if (i_sts.is_alloc || i_sts.is_walk) begin
                    n_state = ST_WALK;
                end else begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_WRAP: begin
                o_cmd.setup = 1'b1;
                o_cmd.wrap  = 1'b1;
                n_wrap      = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk = ~i_sts.empty;
                if (!i_sts.empty && i_sts.hit) begin
                    n_state = ST_DONE;
                end else if (i_sts.empty || i_sts.last) begin
                    if (!i_sts.is_alloc) begin
                        o_cmd.res_ok = 1'b1;
                        n_state      = ST_DONE;
                    end else if (!r_wrap && !i_sts.ptr_start) begin
                        n_state = ST_WRAP;
                    end else begin
                        o_cmd.res_fail  = 1'b1;
                        o_cmd.ptr_reset = 1'b1;
                        n_state         = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

>>> rtl/core/bnfpa_dp.sv
`default_nettype none

module bnfpa_dp #(
    parameter int unsigned BITMAP_BYTES = bnfpa_pkg::BITMAP_BYTES_DEF,
    parameter int unsigned START_PAGE   = bnfpa_pkg::START_PAGE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bnfpa_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic [bnfpa_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [bnfpa_pkg::PNUM_W-1:0]   i_page_number,
    input  logic [bnfpa_pkg::LIMIT_W-1:0]  i_page_count,
    output logic                           o_ok,
    output logic [bnfpa_pkg::PNUM_W-1:0]   o_alloc_page,
    input  bnfpa_pkg::t_dp_cmd             i_cmd,
    output bnfpa_pkg::t_dp_sts             o_sts
);

    import bnfpa_pkg::*;

    localparam int unsigned AW     = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int unsigned NPAGES = 8 * BITMAP_BYTES;

    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] r_ptr;
    logic [TYPE_W-1:0]  r_type;
    logic [PNUM_W-1:0]  r_page;
    logic [LIMIT_W-1:0] r_count;

    t_walk_mode         r_mode, n_mode;
    logic [BYTE_W-1:0]  r_lo_byte, r_hi_byte, r_last_byte;
    logic [2:0]         r_lo_off, r_hi_off;
    logic               r_empty;
    logic [BYTE_W-1:0]  r_rd_byte, r_chk_byte;
    logic               r_chk_vld;
    logic [AW-1:0]      r_init_addr;

    logic               r_res_ok;
    logic [PNUM_W-1:0]  r_res_page;
    logic               r_out_ok;
    logic [PNUM_W-1:0]  r_out_page;

    logic [PAGE_W-1:0]  n_lo, n_hi, n_end, n_hi_m1;
    logic [PAGE_W-1:0]  w_ptr, w_lim, w_page, w_cnt;
    logic               w_is_walk;

    logic               w_inmap;
    logic [7:0]         w_data, w_mlo, w_mhi, w_mask, w_free, w_bit;
    logic [2:0]         w_off;
    logic               w_hit, w_last;
    logic [PAGE_W-1:0]  w_found;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata, ram_rdata;

    // Range setup for the first scan, the wrap scan, or a single page or run of pages.
    always_comb begin
        w_ptr  = PAGE_W'(r_ptr);
        w_lim  = PAGE_W'(r_limit);
        w_page = PAGE_W'(r_page);
        if (r_type == REQ_RUN_FREE || r_type == REQ_RUN_MARK) begin
            w_cnt = PAGE_W'(r_count);
        end else begin
            w_cnt = PAGE_W'(1);
        end
        n_end = w_page + w_cnt;
        if (r_type == REQ_ALLOC) begin
            if (i_cmd.wrap) begin
                n_lo = PAGE_W'(START_PAGE);
                n_hi = (w_ptr < w_lim) ? w_ptr : w_lim;
            end else begin
                n_lo = w_ptr;
                n_hi = w_lim;
            end
        end else begin
            n_lo = w_page;
            n_hi = (32'(n_end) > NPAGES) ? PAGE_W'(NPAGES) : n_end;
        end
        n_hi_m1 = n_hi - PAGE_W'(1);

        unique case (r_type) inside
            REQ_ALLOC:              n_mode = WALK_FIND;
            REQ_FREE, REQ_RUN_FREE: n_mode = WALK_CLR;
            default:                n_mode = WALK_SET;
        endcase

        w_is_walk = (r_type == REQ_MARK) || (r_type == REQ_RUN_FREE)
                 || (r_type == REQ_RUN_MARK)
                 || ((r_type == REQ_FREE) && (r_page != '0)
                     && (LIMIT_W'(r_page) < r_limit));
    end

    // Check stage of the byte walk; the read data belongs to r_chk_byte.
    always_comb begin
        w_inmap = 32'(r_chk_byte) < BITMAP_BYTES;
        w_data  = w_inmap ? ram_rdata : 8'hFF;
        w_mlo   = (r_chk_byte == r_lo_byte) ? (8'hFF >> r_lo_off) : 8'hFF;
        w_mhi   = (r_chk_byte == r_hi_byte) ? ~(8'hFF >> r_hi_off) : 8'hFF;
        w_mask  = w_mlo & w_mhi;
        w_free  = ~w_data & w_mask;
        w_off   = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (w_free[k]) begin
                w_off = 3'(7 - k);
            end
        end
        w_bit   = 8'h80 >> w_off;
        w_hit   = r_chk_vld && (r_mode == WALK_FIND) && (w_free != 8'h00);
        w_last  = r_chk_vld && (r_chk_byte == r_last_byte);
        w_found = {r_chk_byte, w_off};
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_chk_byte);
        ram_wdata = ram_rdata;
        if (i_cmd.init_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_init_addr;
            ram_wdata = 8'hFF;
        end else if (i_cmd.walk && r_chk_vld) begin
            unique case (r_mode)
                WALK_FIND: begin
                    ram_we    = w_hit;
                    ram_wdata = ram_rdata | w_bit;
                end
                WALK_SET: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | w_mask;
                end
                WALK_CLR: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~w_mask;
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    bnfpa_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_rd_byte)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '0;
            r_ptr       <= LIMIT_W'(START_PAGE);
            r_mode      <= WALK_FIND;
            r_empty     <= 1'b1;
            r_chk_vld   <= 1'b0;
            r_init_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.init_step) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (i_cmd.setup) begin
                r_mode    <= n_mode;
                r_empty   <= ~(n_lo < n_hi);
                r_chk_vld <= 1'b0;
            end else if (i_cmd.walk) begin
                r_chk_vld <= 1'b1;
            end
            if (i_cmd.walk && w_hit) begin
                r_ptr <= w_found[LIMIT_W-1:0];
            end else if (i_cmd.ptr_reset) begin
                r_ptr <= LIMIT_W'(START_PAGE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_page  <= i_page_number;
            r_count <= i_page_count;
        end
        if (i_cmd.setup) begin
            r_lo_byte   <= n_lo[PAGE_W-1:3];
            r_lo_off    <= n_lo[2:0];
            r_hi_byte   <= n_hi[PAGE_W-1:3];
            r_hi_off    <= n_hi[2:0];
            r_last_byte <= n_hi_m1[PAGE_W-1:3];
            r_rd_byte   <= n_lo[PAGE_W-1:3];
        end else if (i_cmd.walk) begin
            r_rd_byte  <= r_rd_byte + BYTE_W'(1);
            r_chk_byte <= r_rd_byte;
        end
        if (i_cmd.walk && w_hit) begin
            r_res_ok   <= 1'b1;
            r_res_page <= w_found[PNUM_W-1:0];
        end else if (i_cmd.res_ok) begin
            r_res_ok   <= 1'b1;
            r_res_page <= '0;
        end else if (i_cmd.res_fail) begin
            r_res_ok   <= 1'b0;
            r_res_page <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_ok   <= r_res_ok;
            r_out_page <= r_res_page;
        end
    end

    always_comb begin
        o_sts.init_last = (r_init_addr == AW'(BITMAP_BYTES - 1));
        o_sts.is_alloc  = (r_type == REQ_ALLOC);
        o_sts.is_walk   = w_is_walk;
        o_sts.empty     = r_empty;
        o_sts.hit       = w_hit;
        o_sts.last      = w_last;
        o_sts.ptr_start = (r_ptr == LIMIT_W'(START_PAGE));
    end

    assign o_ok         = r_out_ok;
    assign o_alloc_page = r_out_page;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_next_fit_page_allocator_core.sv
// Channel  Handshake                       Contents
// config   i_cfg_we                        i_cfg_wdata (page limit)
// request  i_in_valid / o_in_ready         i_req_type, i_page_number, i_page_count
// result   o_out_valid / i_out_ready       o_ok, o_alloc_page
//
// After reset the bitmap memory is filled with ones, one byte per cycle, before
// the first word is taken.
// A request passes through setup, a walk over its bitmap bytes and a done state;
// one rejected at setup skips the walk, and a wrapping allocation walks a second range.
// A finished word waits in the output register while the next request runs,
// which holds in its last cycle until that register is free.
`default_nettype none

module bitmap_next_fit_page_allocator_core #(
    parameter int unsigned BITMAP_BYTES = bnfpa_pkg::BITMAP_BYTES_DEF,
    parameter int unsigned START_PAGE   = bnfpa_pkg::START_PAGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bnfpa_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bnfpa_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [bnfpa_pkg::PNUM_W-1:0]  i_page_number,
    input  logic [bnfpa_pkg::LIMIT_W-1:0] i_page_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [bnfpa_pkg::PNUM_W-1:0]  o_alloc_page
);

    import bnfpa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bnfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bnfpa_dp #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .START_PAGE   (START_PAGE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .i_page_count  (i_page_count),
        .o_ok          (o_ok),
        .o_alloc_page  (o_alloc_page),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
module testbench;
    import bnfpa_pkg::*;

    localparam int unsigned TOTAL_PAGES = 8 * BITMAP_BYTES_DEF;
    localparam int unsigned FIRST_PAGE  = START_PAGE_DEF;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned LONG_HOLD   = 400;

    localparam logic [TYPE_W-1:0] REQ_UNUSED_5 = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [PNUM_W-1:0]  page;
        logic [LIMIT_W-1:0] count;
    } page_req_t;

    typedef struct packed {
        logic              ok;
        logic [PNUM_W-1:0] page;
    } page_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [TYPE_W-1:0]   i_req_type = '0;
    logic [PNUM_W-1:0]   i_page_number = '0;
    logic [LIMIT_W-1:0]  i_page_count = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_ok;
    logic [PNUM_W-1:0]   o_alloc_page;

    page_req_t    request_queue[$];
    page_result_t pending_results[$];
    page_req_t    offered_req;

    logic [7:0]  page_map [BITMAP_BYTES_DEF];
    int unsigned next_fit_ptr;
    int unsigned page_limit_now;

    int unsigned requests_queued = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    bit          idle_on = 1'b1;
    bit          rx_hold = 1'b0;
    bit          long_hold_go = 1'b0;
    bit          offer_free;

    bitmap_next_fit_page_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .i_page_count  (i_page_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_alloc_page  (o_alloc_page)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit page_busy(input int unsigned p);
        if (p >= TOTAL_PAGES) begin
            return 1'b1;
        end
        return page_map[p >> 3][7 - (p & 7)];
    endfunction

    function automatic void set_page(input int unsigned p, input bit occupied);
        if (p < TOTAL_PAGES) begin
            page_map[p >> 3][7 - (p & 7)] = occupied;
        end
    endfunction

    function automatic bit find_free(input int unsigned lo, input int unsigned hi,
                                     output int unsigned found);
        found = 0;
        for (int unsigned p = lo; p < hi; p++) begin
            if (!page_busy(p)) begin
                found = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_page_request(input page_req_t r);
        int unsigned found;
        int unsigned hi;
        int unsigned last;
        bit          hit;
        page_result_t res;
        res.ok = 1'b0;
        res.page = '0;
        case (r.kind)
            REQ_ALLOC: begin
                hit = find_free(next_fit_ptr, page_limit_now, found);
                if (!hit && next_fit_ptr != FIRST_PAGE) begin
                    hi = (next_fit_ptr < page_limit_now) ? next_fit_ptr : page_limit_now;
                    hit = find_free(FIRST_PAGE, hi, found);
                end
                if (hit) begin
                    set_page(found, 1'b1);
                    next_fit_ptr = found & 32'hFFFF;
                    res.ok = 1'b1;
                    res.page = found[PNUM_W-1:0];
                end else begin
                    next_fit_ptr = FIRST_PAGE;
                end
            end
            REQ_FREE: begin
                if (r.page != 0 && r.page < page_limit_now) begin
                    set_page(r.page, 1'b0);
                    res.ok = 1'b1;
                end
            end
            REQ_MARK: begin
                set_page(r.page, 1'b1);
                res.ok = 1'b1;
            end
            REQ_RUN_FREE, REQ_RUN_MARK: begin
                last = r.page + r.count;
                if (last > TOTAL_PAGES) begin
                    last = TOTAL_PAGES;
                end
                for (int unsigned p = r.page; p < last; p++) begin
                    set_page(p, r.kind == REQ_RUN_MARK);
                end
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        pending_results.push_back(res);
    endfunction

    task automatic report_error(input string what, input int unsigned got,
                                input int unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer_free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                apply_page_request(offered_req);
                offer_free = 1'b1;
            end
            if (offer_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(0, 11);
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    offered_req = request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= offered_req.kind;
                    i_page_number <= offered_req.page;
                    i_page_count <= offered_req.count;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        page_result_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_error("unexpected word, alloc_page", o_alloc_page, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_ok !== want.ok) begin
                        report_error("ok", o_ok, want.ok);
                    end
                    if (o_alloc_page !== want.page) begin
                        report_error("alloc_page", o_alloc_page, want.page);
                    end
                end
            end
            if (rx_hold) begin
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(0, 11);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (long_hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_req(input logic [TYPE_W-1:0] kind, input int unsigned page,
                             input int unsigned count);
        page_req_t r;
        r.kind = kind;
        r.page = page[PNUM_W-1:0];
        r.count = count[LIMIT_W-1:0];
        request_queue.push_back(r);
        requests_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < requests_queued) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_limit(input int unsigned value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[LIMIT_W-1:0];
        page_limit_now = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic page_req_t random_request(input int unsigned lim);
        page_req_t   r;
        int unsigned pick;
        int unsigned top;
        top = (lim > 32767) ? 32767 : lim;
        pick = $urandom_range(0, 99);
        r.kind = REQ_ALLOC;
        r.page = PNUM_W'($urandom_range(0, 32767));
        r.count = LIMIT_W'($urandom_range(0, 32768));
        if (pick >= 40 && pick < 66) begin
            r.kind = (pick < 58) ? REQ_FREE : REQ_MARK;
            if ($urandom_range(0, 9) < 8) begin
                r.page = PNUM_W'($urandom_range(0, top));
            end
        end else if (pick >= 66 && pick < 88) begin
            r.kind = (pick < 77) ? REQ_RUN_FREE : REQ_RUN_MARK;
            if ($urandom_range(0, 9) < 8) begin
                r.page = PNUM_W'($urandom_range(0, top));
            end
            if ($urandom_range(0, 49) != 0) begin
                r.count = LIMIT_W'($urandom_range(0, 24));
            end
        end else if (pick >= 88 && pick < 91) begin
            r.kind = TYPE_W'($urandom_range(REQ_UNUSED_5, REQ_UNUSED_7));
        end
        return r;
    endfunction

    task automatic run_random_phase(input int unsigned lim, input int unsigned n,
                                    input bit with_idle);
        page_req_t r;
        write_limit(lim);
        idle_on = with_idle;
        if (lim > 30000) begin
            queue_req(REQ_RUN_FREE, 0, 32768);
        end
        repeat (n) begin
            r = random_request(lim);
            queue_req(r.kind, r.page, r.count);
        end
    endtask

    initial begin
        foreach (page_map[i]) begin
            page_map[i] = 8'hFF;
        end
        next_fit_ptr = FIRST_PAGE;
        page_limit_now = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 5, 0);
        queue_req(REQ_FREE, 0, 0);
        queue_req(REQ_MARK, 32767, 0);
        queue_req(REQ_RUN_FREE, 16384, 0);
        queue_req(REQ_UNUSED_5, 32767, 32768);
        queue_req(REQ_UNUSED_7, 0, 32767);

        write_limit(64);
        queue_req(REQ_RUN_FREE, 0, 64);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 64, 0);
        queue_req(REQ_RUN_MARK, 0, 64);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 7, 0);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 5, 0);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 50, 0);
        queue_req(REQ_ALLOC, 0, 0);

        // The roving pointer now sits above the new limit.
        write_limit(20);
        queue_req(REQ_FREE, 3, 0);
        queue_req(REQ_ALLOC, 0, 0);

        write_limit(32768);
        queue_req(REQ_RUN_FREE, 0, 32768);
        queue_req(REQ_RUN_MARK, 32767, 32767);
        queue_req(REQ_RUN_MARK, 0, 32768);
        queue_req(REQ_FREE, 32767, 0);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_ALLOC, 0, 0);

        run_random_phase(300, 200, 1'b1);
        run_random_phase(1000, 200, 1'b1);
        long_hold_go = 1'b1;
        run_random_phase($urandom_range(1, 2000), 150, 1'b1);
        run_random_phase(37, 100, 1'b0);
        run_random_phase(32768, 25, 1'b1);
        run_random_phase(32767, 20, 1'b1);
        run_random_phase(500, 250, 1'b0);
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/bnfpa_pkg.sv
rtl/core/bnfpa_ram.sv
rtl/core/bnfpa_ctrl.sv
rtl/core/bnfpa_dp.sv
rtl/core/bitmap_next_fit_page_allocator_core.sv
bench/testbench.sv
